[rtl/gwcc_pkg.sv]
// Shared types, constants and calendar helpers for the GPS week / calendar converter.
// Used by the controller, the datapath and the top level; depends on nothing else.
package gwcc_pkg;

    localparam int unsigned YEAR_SPAN_DEF = 128;
    localparam int unsigned EPOCH_YEAR_NUM = 1980;

    localparam int unsigned DAY_W   = 17;
    localparam int unsigned SOD_W   = 17;
    localparam int unsigned MUL_A_W = 17;
    localparam int unsigned MUL_B_W = 18;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [11:0] EPOCH_YEAR   = 12'd1980;
    localparam logic [19:0] SEC_PER_DAY  = 20'd86400;
    localparam logic [19:0] SEC_PER_WEEK = 20'd604800;
    localparam logic [DAY_W-1:0] EPOCH_OFFSET = 17'd5;
    localparam logic [5:0]  LEAP_RESET   = 6'd18;
    localparam logic [14:0] WEEK_MAX     = 15'd8191;

    // Reciprocals scaled by 2^20, 2^29 and 2^18; exact for the operand ranges used.
    localparam logic [MUL_B_W-1:0] RECIP_7    = 18'd149797;
    localparam logic [MUL_B_W-1:0] RECIP_3600 = 18'd149131;
    localparam logic [MUL_B_W-1:0] RECIP_60   = 18'd4370;

    localparam logic OPC_TO_WEEK = 1'b0;
    localparam logic OPC_TO_DATE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_YEAR, ST_MONTH, ST_ADD_DAY, ST_SUB_EPOCH,
        ST_WEEK_MUL, ST_WEEK_RES, ST_HOUR_MUL, ST_HOUR_RES, ST_MIN_MUL,
        ST_MIN_RES, ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_INIT, CMD_YEAR_STEP, CMD_MONTH_STEP,
        CMD_ADD_DAY, CMD_SUB_EPOCH, CMD_WEEK_MUL, CMD_WEEK_RES,
        CMD_HOUR_MUL, CMD_HOUR_RES, CMD_MIN_MUL, CMD_MIN_RES
    } t_op_cmd;

    typedef struct packed {
        t_op_cmd op;
        logic    fail;
    } t_cmd;

    typedef struct packed {
        logic to_week;
        logic invalid;
        logic year_hit;
        logic year_last;
        logic month_stop;
        logic before_epoch;
        logic week_ovf;
    } t_stat;

    // Gregorian rule, valid for every year from 1901 to 2399.
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != 12'd2100) && (y != 12'd2200) &&
               (y != 12'd2300);
    endfunction

    function automatic logic [8:0] year_len(input logic [11:0] y);
        return is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    // Month index is zero based.
    function automatic logic [4:0] month_len(input logic [11:0] y, input logic [3:0] m);
        logic [4:0] len;
        case (m) inside
            4'd1:                    len = is_leap(y) ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[rtl/gps_week_calendar_converter_unit.sv]
// The time from input transfer to result valid grows with the year walk and the month walk.
// One item is in flight at a time; the next input transfer is taken in the cycle after
// the result transfer. The walk over years, one per cycle through the shared accumulator,
// sets that time.
// Reset is synchronous and active low: controller to idle, leap seconds to 18.
module gps_week_calendar_converter_unit
    import gwcc_pkg::*;
#(
    parameter int unsigned YEAR_SPAN = YEAR_SPAN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel: leap second offset, GPS minus UTC.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data,
    // Input item channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day_of_month,
    input  logic [4:0]  i_hour_in,
    input  logic [5:0]  i_minute_in,
    input  logic [5:0]  i_second_in,
    input  logic [12:0] i_week_in,
    input  logic [19:0] i_seconds_in_week,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [12:0] o_week_out,
    output logic [19:0] o_seconds_of_week,
    output logic [11:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out,
    output logic        o_status
);

    // The leap second register is only read while forming seconds of week; writes are to be
    // made while the block is idle, which the block itself does not enforce.
    logic [5:0] r_leap_seconds;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leap_seconds <= LEAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_leap_seconds <= i_cfg_data;
        end
    end

    // The controller walks the states; every arithmetic step happens in the datapath
    // on the command that the controller issues in that cycle.
    gwcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // The datapath holds the captured item, the day accumulator that both directions
    // walk year by year and month by month, and the result registers which stay put
    // until the result transfer completes.
    gwcc_dpath #(
        .YEAR_SPAN (YEAR_SPAN)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_leap_seconds    (r_leap_seconds),
        .i_opcode          (i_opcode),
        .i_year            (i_year),
        .i_month           (i_month),
        .i_day_of_month    (i_day_of_month),
        .i_hour_in         (i_hour_in),
        .i_minute_in       (i_minute_in),
        .i_second_in       (i_second_in),
        .i_week_in         (i_week_in),
        .i_seconds_in_week (i_seconds_in_week),
        .o_week_out        (o_week_out),
        .o_seconds_of_week (o_seconds_of_week),
        .o_year_out        (o_year_out),
        .o_month_out       (o_month_out),
        .o_day_out         (o_day_out),
        .o_hour_out        (o_hour_out),
        .o_minute_out      (o_minute_out),
        .o_second_out      (o_second_out),
        .o_status          (o_status)
    );

    // The input side only opens while no result is pending.
    a_no_accept_while_result : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid
    ) else $error("input open while a result is pending");

    // After an input transfer the block is busy in the following cycle.
    a_busy_after_accept : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !o_out_valid)
    ) else $error("block not busy after input transfer");

    // A flagged result carries all fields cleared.
    a_fail_fields_zero : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |->
            (o_week_out == 13'd0 && o_seconds_of_week == 20'd0 && o_year_out == 12'd0 &&
             o_month_out == 4'd0 && o_day_out == 5'd0 && o_hour_out == 5'd0 &&
             o_minute_out == 6'd0 && o_second_out == 6'd0)
    ) else $error("flagged result with non-zero fields");

endmodule

[rtl/gwcc_ctrl.sv]
// Sequencing state machine of the GPS week / calendar converter.
// Depends on gwcc_pkg; drives the datapath through t_cmd and reads t_stat back.
module gwcc_ctrl
    import gwcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall,
    output logic  o_out_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_stat.invalid ? ST_DONE : ST_YEAR;
            end
            ST_YEAR: begin
                if (i_stat.year_hit) begin
                    n_state = ST_MONTH;
                end else if (!i_stat.to_week && i_stat.year_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_MONTH: begin
                if (i_stat.month_stop) n_state = i_stat.to_week ? ST_ADD_DAY : ST_HOUR_MUL;
            end
            ST_ADD_DAY:   n_state = ST_SUB_EPOCH;
            ST_SUB_EPOCH: n_state = i_stat.before_epoch ? ST_DONE : ST_WEEK_MUL;
            ST_WEEK_MUL:  n_state = ST_WEEK_RES;
            ST_WEEK_RES:  n_state = ST_DONE;
            ST_HOUR_MUL:  n_state = ST_HOUR_RES;
            ST_HOUR_RES:  n_state = ST_MIN_MUL;
            ST_MIN_MUL:   n_state = ST_MIN_RES;
            ST_MIN_RES:   n_state = ST_DONE;
            ST_DONE: begin
                if (!i_out_stall) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op    = CMD_NONE;
        o_cmd.fail  = 1'b0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) o_cmd.op = CMD_LOAD;
            end
            ST_CHECK: begin
                o_cmd.op   = CMD_INIT;
                o_cmd.fail = i_stat.invalid;
            end
            ST_YEAR: begin
                if (!i_stat.year_hit) begin
                    if (!i_stat.to_week && i_stat.year_last) begin
                        o_cmd.fail = 1'b1;
                    end else begin
                        o_cmd.op = CMD_YEAR_STEP;
                    end
                end
            end
            ST_MONTH: begin
                if (!i_stat.month_stop) o_cmd.op = CMD_MONTH_STEP;
            end
            ST_ADD_DAY: o_cmd.op = CMD_ADD_DAY;
            ST_SUB_EPOCH: begin
                if (i_stat.before_epoch) begin
                    o_cmd.fail = 1'b1;
                end else begin
                    o_cmd.op = CMD_SUB_EPOCH;
                end
            end
            ST_WEEK_MUL: o_cmd.op = CMD_WEEK_MUL;
            ST_WEEK_RES: begin
                if (i_stat.week_ovf) begin
                    o_cmd.fail = 1'b1;
                end else begin
                    o_cmd.op = CMD_WEEK_RES;
                end
            end
            ST_HOUR_MUL: o_cmd.op = CMD_HOUR_MUL;
            ST_HOUR_RES: o_cmd.op = CMD_HOUR_RES;
            ST_MIN_MUL:  o_cmd.op = CMD_MIN_MUL;
            ST_MIN_RES:  o_cmd.op = CMD_MIN_RES;
            ST_DONE:     o_out_valid = 1'b1;
            default:     o_cmd.op = CMD_NONE;
        endcase
    end

endmodule

[rtl/gwcc_dpath.sv]
// Datapath of the GPS week / calendar converter: operand and result registers,
// the year and month walk accumulator and one shared constant multiplier. Depends on gwcc_pkg.
module gwcc_dpath
    import gwcc_pkg::*;
#(
    parameter int unsigned YEAR_SPAN = YEAR_SPAN_DEF
) (
    input  logic        i_clk,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [5:0]  i_leap_seconds,
    input  logic        i_opcode,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day_of_month,
    input  logic [4:0]  i_hour_in,
    input  logic [5:0]  i_minute_in,
    input  logic [5:0]  i_second_in,
    input  logic [12:0] i_week_in,
    input  logic [19:0] i_seconds_in_week,
    output logic [12:0] o_week_out,
    output logic [19:0] o_seconds_of_week,
    output logic [11:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out,
    output logic        o_status
);

    localparam logic [11:0] YEAR_LAST = 12'(EPOCH_YEAR_NUM + YEAR_SPAN - 1);

    // Captured item.
    logic               r_op;
    logic [11:0]        r_yr;
    logic [3:0]         r_mo;
    logic [4:0]         r_dy;
    logic [4:0]         r_hr;
    logic [5:0]         r_mi;
    logic [5:0]         r_se;
    logic [12:0]        r_wk;
    logic [19:0]        r_sow;

    // Working registers.
    logic [11:0]        r_y;
    logic [3:0]         r_m;
    logic [DAY_W-1:0]   r_days;
    logic [SOD_W-1:0]   r_tod;
    logic [SOD_W-1:0]   r_sod;
    logic [11:0]        r_rem;
    logic [MUL_P_W-1:0] r_prod;

    // Results.
    logic [12:0]        r_week_out;
    logic [19:0]        r_sow_out;
    logic [11:0]        r_year_out;
    logic [3:0]         r_month_out;
    logic [4:0]         r_day_out;
    logic [4:0]         r_hour_out;
    logic [5:0]         r_minute_out;
    logic [5:0]         r_second_out;
    logic               r_status;

    logic [2:0]         day_idx;
    logic [SOD_W-1:0]   sod_init;
    logic [DAY_W-1:0]   doy_init;
    logic [SOD_W-1:0]   tod_init;
    logic [8:0]         ylen;
    logic [4:0]         mlen;
    logic               bad_date;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [14:0]        week_q;
    logic [DAY_W-1:0]   week_q17;
    logic [DAY_W-1:0]   week_rem;
    logic [4:0]         hour_q;
    logic [11:0]        hour_rem;
    logic [5:0]         min_q;
    logic [11:0]        min_rem;

    // Day of week, second of day and day count of the week time input, and time of day of the calendar input.
    always_comb begin
        day_idx = 3'd0;
        for (int k = 1; k < 7; k++) begin
            day_idx = day_idx + 3'(r_sow >= 20'(k * 86400));
        end
        sod_init = SOD_W'(r_sow - 20'(day_idx) * SEC_PER_DAY);
        doy_init = DAY_W'(r_wk) * DAY_W'(7) + DAY_W'(day_idx) + EPOCH_OFFSET;
        tod_init = SOD_W'(r_hr) * SOD_W'(3600) + SOD_W'(r_mi) * SOD_W'(60) + SOD_W'(r_se);
    end

    assign ylen = year_len(r_y);
    assign mlen = month_len(r_y, r_m);

    always_comb begin
        if (r_op == OPC_TO_WEEK) begin
            bad_date = (r_yr < EPOCH_YEAR) || (r_yr > YEAR_LAST) ||
                       (r_mo == 4'd0) || (r_mo > 4'd12) || (r_dy == 5'd0) ||
                       (r_dy > month_len(r_yr, r_mo - 4'd1)) ||
                       (r_hr > 5'd23) || (r_mi > 6'd59) || (r_se > 6'd59);
        end else begin
            bad_date = (r_sow >= SEC_PER_WEEK);
        end
    end

    assign o_stat.to_week      = (r_op == OPC_TO_WEEK);
    assign o_stat.invalid      = bad_date;
    assign o_stat.year_hit     = (r_op == OPC_TO_WEEK) ? (r_y == r_yr)
                                                       : (r_days < DAY_W'(ylen));
    assign o_stat.year_last    = (r_y == YEAR_LAST);
    assign o_stat.month_stop   = (r_op == OPC_TO_WEEK)
                                 ? (r_m + 4'd1 == r_mo)
                                 : ((r_m == 4'd11) || (r_days < DAY_W'(mlen)));
    assign o_stat.before_epoch = (r_days < EPOCH_OFFSET);
    assign o_stat.week_ovf     = (week_q > WEEK_MAX);

    // Shared multiplier operand selection.
    always_comb begin
        case (i_cmd.op)
            CMD_HOUR_MUL: begin
                mul_a = MUL_A_W'(r_sod);
                mul_b = RECIP_3600;
            end
            CMD_MIN_MUL: begin
                mul_a = MUL_A_W'(r_rem);
                mul_b = RECIP_60;
            end
            default: begin
                mul_a = MUL_A_W'(r_days);
                mul_b = RECIP_7;
            end
        endcase
    end

    always_comb begin
        week_q   = r_prod[MUL_P_W-1:20];
        week_q17 = DAY_W'(week_q);
        week_rem = r_days - ((week_q17 << 3) - week_q17);
        hour_q   = r_prod[33:29];
        hour_rem = 12'(r_sod - SOD_W'(hour_q) * SOD_W'(3600));
        min_q    = r_prod[23:18];
        min_rem  = r_rem - 12'(min_q) * 12'd60;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
        if (i_cmd.fail) r_status <= 1'b1;
        case (i_cmd.op)
            CMD_LOAD: begin
                r_op         <= i_opcode;
                r_yr         <= i_year;
                r_mo         <= i_month;
                r_dy         <= i_day_of_month;
                r_hr         <= i_hour_in;
                r_mi         <= i_minute_in;
                r_se         <= i_second_in;
                r_wk         <= i_week_in;
                r_sow        <= i_seconds_in_week;
                r_week_out   <= '0;
                r_sow_out    <= '0;
                r_year_out   <= '0;
                r_month_out  <= '0;
                r_day_out    <= '0;
                r_hour_out   <= '0;
                r_minute_out <= '0;
                r_second_out <= '0;
                r_status     <= 1'b0;
            end
            CMD_INIT: begin
                r_y    <= EPOCH_YEAR;
                r_m    <= 4'd0;
                r_days <= (r_op == OPC_TO_WEEK) ? '0 : doy_init;
                r_tod  <= tod_init;
                r_sod  <= sod_init;
            end
            CMD_YEAR_STEP: begin
                r_days <= (r_op == OPC_TO_WEEK) ? r_days + DAY_W'(ylen)
                                                : r_days - DAY_W'(ylen);
                r_y    <= r_y + 12'd1;
            end
            CMD_MONTH_STEP: begin
                r_days <= (r_op == OPC_TO_WEEK) ? r_days + DAY_W'(mlen)
                                                : r_days - DAY_W'(mlen);
                r_m    <= r_m + 4'd1;
            end
            CMD_ADD_DAY: begin
                r_days <= r_days + DAY_W'(r_dy) - DAY_W'(1);
            end
            CMD_SUB_EPOCH: begin
                r_days <= r_days - EPOCH_OFFSET;
            end
            CMD_WEEK_RES: begin
                r_week_out <= week_q[12:0];
                r_sow_out  <= 20'(week_rem[2:0]) * SEC_PER_DAY + 20'(r_tod) +
                              20'(i_leap_seconds);
            end
            CMD_HOUR_MUL: begin
                r_year_out  <= r_y;
                r_month_out <= r_m + 4'd1;
                r_day_out   <= 5'(r_days + DAY_W'(1));
            end
            CMD_HOUR_RES: begin
                r_hour_out <= hour_q;
                r_rem      <= hour_rem;
            end
            CMD_MIN_RES: begin
                r_minute_out <= min_q;
                r_second_out <= min_rem[5:0];
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_week_out        = r_week_out;
    assign o_seconds_of_week = r_sow_out;
    assign o_year_out        = r_year_out;
    assign o_month_out       = r_month_out;
    assign o_day_out         = r_day_out;
    assign o_hour_out        = r_hour_out;
    assign o_minute_out      = r_minute_out;
    assign o_second_out      = r_second_out;
    assign o_status          = r_status;

endmodule
